FILE: design/sitda_pkg.sv
// Shared types and constants for the signed integer to decimal text converter.
package sitda_pkg;

    localparam int DEFAULT_VALUE_BITS = 32;

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
    localparam logic [3:0] BCD_ADJ     = 4'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SIGN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic clear;
        logic shift;
        logic move;
    } t_cell_ctl;

endpackage

FILE: design/sitda_cell.sv
// One decimal digit cell: add-3 shift step during conversion, digit hand-up during output.
module sitda_cell
    import sitda_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctl  i_ctl,
    input  logic       i_bit,
    input  logic [3:0] i_digit_lo,
    output logic       o_carry,
    output logic [3:0] o_digit
);

    logic [3:0] r_digit;
    logic [3:0] w_adj;

    assign w_adj   = (r_digit >= BCD_ADJ_MIN) ? (r_digit + BCD_ADJ) : r_digit;
    assign o_carry = w_adj[3];
    assign o_digit = r_digit;

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_digit <= 4'd0;
        end else if (i_ctl.shift) begin
            r_digit <= {w_adj[2:0], i_bit};
        end else if (i_ctl.move) begin
            r_digit <= i_digit_lo;
        end
    end

endmodule

FILE: design/sitda_ctrl.sv
// Sequencer: magnitude shift register, conversion and output control, result registers.
module sitda_ctrl
    import sitda_pkg::*;
#(
    parameter int VALUE_BITS = DEFAULT_VALUE_BITS,
    parameter int NDIG       = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic [3:0]            i_top_digit,
    output logic                  o_busy,
    output logic                  o_bit,
    output t_cell_ctl             o_ctl,
    output logic                  o_valid,
    output logic [7:0]            o_character,
    output logic                  o_last
);

    localparam int CNT_W  = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    localparam int LEFT_W = $clog2(NDIG + 1);

    t_state                r_state, n_state;
    logic [VALUE_BITS-1:0] r_mag, n_mag;
    logic                  r_neg, n_neg;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [LEFT_W-1:0]     r_left, n_left;
    logic                  r_lead, n_lead;
    logic                  r_valid, n_valid;
    logic [7:0]            r_char, n_char;
    logic                  r_last, n_last;

    assign o_busy      = (r_state != ST_IDLE);
    assign o_bit       = r_mag[VALUE_BITS-1];
    assign o_valid     = r_valid;
    assign o_character = r_char;
    assign o_last      = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_mag  <= n_mag;
        r_neg  <= n_neg;
        r_cnt  <= n_cnt;
        r_left <= n_left;
        r_lead <= n_lead;
        r_char <= n_char;
        r_last <= n_last;
    end

    always_comb begin
        n_state = r_state;
        n_mag   = r_mag;
        n_neg   = r_neg;
        n_cnt   = r_cnt;
        n_left  = r_left;
        n_lead  = r_lead;
        n_valid = 1'b0;
        n_char  = r_char;
        n_last  = r_last;
        o_ctl   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_neg      = i_value[VALUE_BITS-1];
                    n_mag      = i_value[VALUE_BITS-1] ? (~i_value + 1'b1) : i_value;
                    n_cnt      = CNT_W'(VALUE_BITS - 1);
                    o_ctl.clear = 1'b1;
                    n_state    = ST_CONVERT;
                end
            end
            ST_CONVERT: begin
                o_ctl.shift = 1'b1;
                n_mag       = {r_mag[VALUE_BITS-2:0], 1'b0};
                n_cnt       = r_cnt - 1'b1;
                n_left      = LEFT_W'(NDIG);
                n_lead      = 1'b1;
                if (r_cnt == '0) begin
                    n_state = r_neg ? ST_SIGN : ST_OUT;
                end
            end
            ST_SIGN: begin
                n_valid = 1'b1;
                n_char  = CHAR_MINUS;
                n_last  = 1'b0;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                o_ctl.move = 1'b1;
                n_left     = r_left - 1'b1;
                if (!(r_lead && (i_top_digit == 4'd0) && (r_left > LEFT_W'(1)))) begin
                    n_lead  = 1'b0;
                    n_valid = 1'b1;
                    n_char  = CHAR_ZERO + {4'd0, i_top_digit};
                    n_last  = (r_left == LEFT_W'(1));
                    if (r_left == LEFT_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: design/signed_int_to_decimal_ascii.sv
// Top level: signed integer to decimal ASCII text, one character per cycle during output,
// but for dropped leading zeros. Steps: a shift-and-adjust pass over every value bit, a '-'
// word when negative, then NDIG digit positions from the top; each dropped zero gives no word
// and delays the first digit. A new value is accepted only when idle, once the text is out.
// The receiver cannot stall; busy drops in the cycle that shows the last word.
// Reset (synchronous, active low) returns the sequencer to idle and drops the strobe.
module signed_int_to_decimal_ascii
    import sitda_pkg::*;
#(
    parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic                  o_busy,
    output logic                  o_valid,
    output logic [7:0]            o_character,
    output logic                  o_last
);

    localparam int NDIG = ((VALUE_BITS - 1) * 30103) / 100000 + 1;

    t_cell_ctl        w_ctl;
    logic [NDIG:0]    w_carry;
    logic [3:0]       w_digit [NDIG];

    sitda_ctrl #(
        .VALUE_BITS (VALUE_BITS),
        .NDIG       (NDIG)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_value     (i_value),
        .i_top_digit (w_digit[NDIG-1]),
        .o_busy      (o_busy),
        .o_bit       (w_carry[0]),
        .o_ctl       (w_ctl),
        .o_valid     (o_valid),
        .o_character (o_character),
        .o_last      (o_last)
    );

    for (genvar g = 0; g < NDIG; g++) begin : g_cell
        logic [3:0] w_lo;
        if (g == 0) begin : g_first
            assign w_lo = 4'd0;
        end else begin : g_rest
            assign w_lo = w_digit[g-1];
        end
        sitda_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_bit      (w_carry[g]),
            .i_digit_lo (w_lo),
            .o_carry    (w_carry[g+1]),
            .o_digit    (w_digit[g])
        );
    end

endmodule

FILE: design/sitda_checker.sv
// Port-level checker for the decimal text converter, bound to the top level.
module sitda_checker
    import sitda_pkg::*;
#(
    parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_start,
    input logic [VALUE_BITS-1:0] i_value,
    input logic                  o_busy,
    input logic                  o_valid,
    input logic [7:0]            o_character,
    input logic                  o_last
);

    a_char_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_character == CHAR_MINUS) ||
                    ((o_character >= CHAR_ZERO) && (o_character <= CHAR_ZERO + 8'd9)))
        else $error("word is neither minus nor digit");

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_character == CHAR_MINUS)) |-> (!o_last && o_busy))
        else $error("minus sign ends text or comes after busy drops");

    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !o_valid)
        else $error("word follows the last word of a value");

    a_start_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_value == i_value)) |=> (o_busy && !o_valid))
        else $error("accepted value gives no busy or an early word");

    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_busy) |-> o_last)
        else $error("word shown while idle is not the last one");

endmodule

bind signed_int_to_decimal_ascii sitda_checker #(
    .VALUE_BITS (VALUE_BITS)
) u_sitda_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .i_value     (i_value),
    .o_busy      (o_busy),
    .o_valid     (o_valid),
    .o_character (o_character),
    .o_last      (o_last)
);

FILE: tb/sv/decimal_text_checker.sv
`timescale 1ns / 1ps
// Checker that predicts the decimal text of each accepted value and compares it word by word.
module decimal_text_checker
    import sitda_pkg::*;
#(
    parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic                  i_valid,
    input  logic [7:0]            i_character,
    input  logic                  i_last,
    output int                    o_pending,
    output int                    o_mismatches
);

    localparam int MAX_DIGITS = 20;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } t_text_word;

    t_text_word expected_words[$];

    function automatic void predict_text(input logic [VALUE_BITS-1:0] value);
        logic                  negative;
        logic [VALUE_BITS-1:0] magnitude_w;
        logic [63:0]           magnitude;
        logic [3:0]            digits[MAX_DIGITS];
        int                    ndig;
        negative    = value[VALUE_BITS-1];
        magnitude_w = negative ? (~value + 1'b1) : value;
        magnitude   = 64'(magnitude_w);
        ndig        = 0;
        do begin
            digits[ndig] = 4'(magnitude % 10);
            ndig++;
            magnitude = magnitude / 10;
        end while (magnitude != 0 && ndig < MAX_DIGITS);
        if (negative) begin
            expected_words.push_back('{character: CHAR_MINUS, last: 1'b0});
        end
        for (int k = ndig - 1; k >= 0; k--) begin
            expected_words.push_back('{character: CHAR_ZERO + 8'(digits[k]), last: (k == 0)});
        end
    endfunction

    initial o_mismatches = 0;

    always @(posedge i_clk) begin
        t_text_word want;
        if (i_rst_n) begin
            if (i_start && !i_busy) begin
                predict_text(i_value);
            end
            if (i_valid) begin
                if (expected_words.size() == 0) begin
                    $error("character 0x%02h last %0b with no word expected",
                           i_character, i_last);
                    o_mismatches++;
                end else begin
                    want = expected_words.pop_front();
                    if (i_character !== want.character) begin
                        $error("character: expected 0x%02h, got 0x%02h",
                               want.character, i_character);
                        o_mismatches++;
                    end
                    if (i_last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, i_last);
                        o_mismatches++;
                    end
                end
            end
        end
        o_pending <= expected_words.size();
    end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Top testbench: drives values into the converter, watches for stalls and gives the verdict.
module tb;
    import sitda_pkg::*;

    localparam int VALUE_BITS   = DEFAULT_VALUE_BITS;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = VALUE_BITS + 16;
    localparam int RANDOM_ITEMS = 340;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_start = 1'b0;
    logic [VALUE_BITS-1:0] i_value = '0;
    logic                  o_busy;
    logic                  o_valid;
    logic [7:0]            o_character;
    logic                  o_last;
    int                    pending;
    int                    mismatches;
    int                    stall_cycles = 0;
    bit                    idle_on      = 1'b1;

    logic [VALUE_BITS-1:0] corner_values[$] = '{
        32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
        32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
        32'd999999999, -32'sd999999999, -32'sd1000000000, 32'h5555_5555,
        32'haaaa_aaaa, 32'd12345, -32'sd12345, 32'd7, -32'sd7, 32'd1999999999
    };

    always #5 i_clk = ~i_clk;

    signed_int_to_decimal_ascii #(
        .VALUE_BITS(VALUE_BITS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_value    (i_value),
        .o_busy     (o_busy),
        .o_valid    (o_valid),
        .o_character(o_character),
        .o_last     (o_last)
    );

    decimal_text_checker #(
        .VALUE_BITS(VALUE_BITS)
    ) i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_busy      (o_busy),
        .i_value     (i_value),
        .i_valid     (o_valid),
        .i_character (o_character),
        .i_last      (o_last),
        .o_pending   (pending),
        .o_mismatches(mismatches)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic logic [VALUE_BITS-1:0] random_value();
        int unsigned           kind;
        int unsigned           ndig;
        int unsigned           lo;
        int unsigned           hi;
        int unsigned           mag;
        longint unsigned       p;
        logic                  neg;
        logic [VALUE_BITS-1:0] v;
        kind = $urandom_range(0, 9);
        neg  = 1'($urandom_range(0, 1));
        if (kind < 3) begin
            return $urandom;
        end
        if (kind == 3) begin
            p = 1;
            repeat ($urandom_range(0, 9)) p = p * 10;
            mag = int'(p) + $urandom_range(0, 2) - 1;
        end else begin
            ndig = $urandom_range(1, 10);
            p = 1;
            repeat (ndig - 1) p = p * 10;
            lo = (ndig == 1) ? 0 : int'(p);
            if (ndig == 10) begin
                hi = neg ? 32'h8000_0000 : 32'h7fff_ffff;
            end else begin
                hi = int'(p * 10 - 1);
            end
            mag = $urandom_range(hi, lo);
        end
        v = mag[VALUE_BITS-1:0];
        return neg ? (~v + 1'b1) : v;
    endfunction

    task automatic send_value(input logic [VALUE_BITS-1:0] value);
        int gap;
        gap = idle_on ? $urandom_range(0, 17) : 0;
        if (gap != 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (o_busy);
    endtask

    task automatic hold_until_drained();
        i_start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (corner_values[n]) begin
            send_value(corner_values[n]);
        end
        hold_until_drained();
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) begin
                idle_on = ($urandom_range(0, 3) != 0);
            end
            if (n == RANDOM_ITEMS / 2) begin
                hold_until_drained();
            end
            send_value(random_value());
        end
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

FILE: files.f
design/sitda_pkg.sv
design/sitda_cell.sv
design/sitda_ctrl.sv
design/signed_int_to_decimal_ascii.sv
design/sitda_checker.sv
tb/sv/decimal_text_checker.sv
tb/sv/tb.sv
